### rtl/hrhc_pkg.sv
// shared types, keyword tables and codes of the http reply header classifier
package hrhc_pkg;

  localparam int HEADER_LIMIT = 8191;
  localparam int HDR_W        = 13;
  localparam int NUM_KEYS     = 6;
  localparam int MAGIC_LEN    = 5;

  typedef enum logic [2:0] {
    VERDICT_PUBLIC   = 3'd0,
    VERDICT_PRIVATE  = 3'd1,
    VERDICT_NEGATIVE = 3'd2,
    VERDICT_NOT_HTTP = 3'd3,
    VERDICT_OVERFLOW = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    FLD_CODE    = 3'd0,
    FLD_CTYPE   = 3'd1,
    FLD_CLEN    = 3'd2,
    FLD_DATE    = 3'd3,
    FLD_EXPIRES = 3'd4,
    FLD_LM      = 3'd5,
    FLD_NONE    = 3'd6
  } field_t;

  localparam int FLAG_DATE  = 0;
  localparam int FLAG_EXP   = 1;
  localparam int FLAG_LM    = 2;
  localparam int FLAG_CTYPE = 3;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // keyword text, lower case, padded to 16 characters
  localparam logic [127:0] KEY_TEXT [NUM_KEYS] = '{
    "http            ",
    "content-type:   ",
    "content-length: ",
    "date:           ",
    "expires:        ",
    "last-modified:  "
  };
  localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{4'd4, 4'd13, 4'd15, 4'd5, 4'd8, 4'd14};

  localparam logic [8*MAGIC_LEN-1:0] MAGIC = "HTTP/";

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_reply;
  } in_word_t;

  typedef struct packed {
    verdict_t          verdict;
    logic [15:0]       status_code;
    logic [31:0]       body_length;
    logic              has_date;
    logic              has_expires;
    logic              has_last_modified;
    logic              has_content_type;
    logic [HDR_W-1:0]  header_size;
  } result_t;

  function automatic logic [7:0] key_char(input int k, input logic [3:0] idx);
    logic [3:0] pos;
    pos = 4'd15 - idx;
    return KEY_TEXT[k][{pos, 3'b000} +: 8];
  endfunction

  // expected byte at header position pos (1 to MAGIC_LEN)
  function automatic logic [7:0] magic_char(input logic [2:0] pos);
    logic [2:0] sel;
    sel = 3'(MAGIC_LEN) - pos;
    return MAGIC[{sel, 3'b000} +: 8];
  endfunction

endpackage

### rtl/hrhc_in_stage.sv
// input register stage of the header classifier
module hrhc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte_value,
  input  logic              in_start_reply,
  input  logic              take,
  output logic              word_valid,
  output hrhc_pkg::in_word_t word
);
  import hrhc_pkg::*;

  logic     valid_r, valid_nxt;
  in_word_t word_r;

  assign in_ready   = !valid_r || take;
  assign word_valid = valid_r;
  assign word       = word_r;

  always_comb begin
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      word_r.byte_value  <= in_byte_value;
      word_r.start_reply <= in_start_reply;
    end
  end

endmodule

### rtl/hrhc_parser.sv
// parse state and per-byte update logic of the header classifier
module hrhc_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  hrhc_pkg::in_word_t word,
  output logic               res_valid,
  output hrhc_pkg::result_t  res
);
  import hrhc_pkg::*;

  typedef enum logic [1:0] {
    VP_SKIP  = 2'd0,
    VP_PLUS  = 2'd1,
    VP_MINUS = 2'd2,
    VP_DONE  = 2'd3
  } val_phase_t;

  logic             phase_r, phase_nxt;
  logic [HDR_W-1:0] hdr_len_r, hdr_len_nxt;
  logic [HDR_W-1:0] line_len_r, line_len_nxt;
  logic [NUM_KEYS-1:0] kw_mask_r, kw_mask_nxt;
  logic [1:0]       blank_r, blank_nxt;
  logic             seen_space_r, seen_space_nxt;
  val_phase_t       vphase_r, vphase_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [15:0]      code_r, code_nxt;
  logic [31:0]      clen_r, clen_nxt;
  logic [3:0]       flags_r, flags_nxt;

  // values after an optional start_reply clear
  logic             phase_b;
  logic [HDR_W-1:0] hdr_len_b, line_len_b;
  logic [NUM_KEYS-1:0] kw_mask_b;
  logic [1:0]       blank_b;
  logic             seen_space_b;
  val_phase_t       vphase_b;
  logic [31:0]      acc_b, clen_b;
  logic [15:0]      code_b;
  logic [3:0]       flags_b;

  logic [7:0]       b, c;
  logic [NUM_KEYS-1:0] m;
  field_t           fld;
  logic             is_digit, is_blank;
  logic [35:0]      acc_wide;
  logic [31:0]      acc_new;
  logic             emit;
  verdict_t         verdict;

  function automatic field_t active(input logic [NUM_KEYS-1:0] mask);
    field_t f;
    f = FLD_NONE;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (mask[k]) f = field_t'(3'(k));
    end
    return f;
  endfunction

  function automatic verdict_t classify(input logic [15:0] code, input logic exp);
    verdict_t v;
    unique case (code)
      16'd200, 16'd203, 16'd300, 16'd301, 16'd410: v = VERDICT_PUBLIC;
      16'd302: v = exp ? VERDICT_PUBLIC : VERDICT_PRIVATE;
      16'd204, 16'd305, 16'd400, 16'd403, 16'd404, 16'd405, 16'd414,
      16'd500, 16'd501, 16'd502, 16'd503, 16'd504:
        v = exp ? VERDICT_PUBLIC : VERDICT_NEGATIVE;
      default: v = VERDICT_PRIVATE;
    endcase
    return v;
  endfunction

  always_comb begin
    b = word.byte_value;
    if (word.start_reply) begin
      phase_b = 1'b0;  hdr_len_b = '0;  line_len_b = '0;  kw_mask_b = '1;
      blank_b = '0;    seen_space_b = 1'b0;  vphase_b = VP_SKIP;  acc_b = '0;
      code_b = '0;     clen_b = '0;   flags_b = '0;
    end else begin
      phase_b = phase_r;  hdr_len_b = hdr_len_r;  line_len_b = line_len_r;
      kw_mask_b = kw_mask_r;  blank_b = blank_r;  seen_space_b = seen_space_r;
      vphase_b = vphase_r;  acc_b = acc_r;  code_b = code_r;  clen_b = clen_r;
      flags_b = flags_r;
    end

    phase_nxt = phase_b;  hdr_len_nxt = hdr_len_b;  line_len_nxt = line_len_b;
    kw_mask_nxt = kw_mask_b;  blank_nxt = blank_b;  seen_space_nxt = seen_space_b;
    vphase_nxt = vphase_b;  acc_nxt = acc_b;  code_nxt = code_b;  clen_nxt = clen_b;
    flags_nxt = flags_b;

    c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    is_digit = (b >= "0" && b <= "9");
    is_blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_VT) ||
               (b == CH_FF);
    m = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (kw_mask_b[k] && (line_len_b >= HDR_W'(KEY_LEN[k]) ||
                           c == key_char(k, line_len_b[3:0]))) begin
        m[k] = 1'b1;
      end
    end
    fld = seen_space_b ? active(kw_mask_b) : active(m);
    // acc * 10 + digit, saturated to 32 bits
    acc_wide = {acc_b, 3'b000} + {3'b000, acc_b, 1'b0} + {32'd0, b[3:0]};
    acc_new  = (acc_wide[35:32] != 4'd0) ? 32'hffff_ffff : acc_wide[31:0];

    emit = 1'b0;
    verdict = VERDICT_PRIVATE;

    if (!phase_b) begin
      hdr_len_nxt = hdr_len_b + HDR_W'(1);
      if (hdr_len_nxt <= HDR_W'(MAGIC_LEN) && b != magic_char(hdr_len_nxt[2:0])) begin
        emit = 1'b1;
        verdict = VERDICT_NOT_HTTP;
      end else if (b == CH_LF && blank_b != 2'd0) begin
        emit = 1'b1;
        verdict = classify(code_b, flags_b[FLAG_EXP]);
      end else begin
        if (b == CH_LF) begin
          blank_nxt = 2'd1;
          line_len_nxt = '0;
          kw_mask_nxt = '1;
          seen_space_nxt = 1'b0;
          vphase_nxt = VP_SKIP;
          acc_nxt = '0;
        end else begin
          blank_nxt = (b == CH_CR && blank_b != 2'd0) ? 2'd2 : 2'd0;
          if (!seen_space_b) begin
            kw_mask_nxt = m;
            if (b == CH_SPACE) begin
              seen_space_nxt = 1'b1;
              vphase_nxt = VP_SKIP;
              acc_nxt = '0;
              unique case (fld)
                FLD_CODE:    code_nxt = '0;
                FLD_CLEN:    clen_nxt = '0;
                FLD_DATE:    flags_nxt[FLAG_DATE] = 1'b1;
                FLD_EXPIRES: flags_nxt[FLAG_EXP] = 1'b0;
                FLD_LM:      flags_nxt[FLAG_LM] = 1'b1;
                FLD_CTYPE:   flags_nxt[FLAG_CTYPE] = 1'b1;
                default: ;
              endcase
            end
          end else begin
            if (b != CH_CR && fld == FLD_EXPIRES) flags_nxt[FLAG_EXP] = 1'b1;
            if (vphase_b == VP_SKIP && !is_digit) begin
              if (!is_blank) begin
                vphase_nxt = (b == CH_PLUS) ? VP_PLUS : (b == CH_MINUS) ? VP_MINUS : VP_DONE;
              end
            end else if (vphase_b == VP_DONE) begin
              vphase_nxt = VP_DONE;
            end else if (!is_digit) begin
              vphase_nxt = VP_DONE;
            end else begin
              if (vphase_b == VP_SKIP) vphase_nxt = VP_PLUS;
              acc_nxt = acc_new;
              if (fld == FLD_CODE) begin
                code_nxt = (vphase_b == VP_MINUS) ? 16'd0 :
                           (acc_new[31:16] != 16'd0) ? 16'hffff : acc_new[15:0];
              end else if (fld == FLD_CLEN) begin
                clen_nxt = (vphase_b == VP_MINUS) ? 32'd0 : acc_new;
              end
            end
          end
          if (line_len_b != HDR_W'(HEADER_LIMIT)) line_len_nxt = line_len_b + HDR_W'(1);
        end
        if (hdr_len_nxt >= HDR_W'(HEADER_LIMIT)) begin
          emit = 1'b1;
          verdict = VERDICT_OVERFLOW;
        end
      end
      if (emit) phase_nxt = 1'b1;
    end

    res.verdict           = verdict;
    res.status_code       = code_nxt;
    res.body_length       = clen_nxt;
    res.has_date          = flags_nxt[FLAG_DATE];
    res.has_expires       = flags_nxt[FLAG_EXP];
    res.has_last_modified = flags_nxt[FLAG_LM];
    res.has_content_type  = flags_nxt[FLAG_CTYPE];
    res.header_size       = hdr_len_nxt;
    res_valid             = emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;  hdr_len_r <= '0;  line_len_r <= '0;  kw_mask_r <= '1;
      blank_r <= '0;    seen_space_r <= 1'b0;  vphase_r <= VP_SKIP;  acc_r <= '0;
      code_r <= '0;     clen_r <= '0;   flags_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;  hdr_len_r <= hdr_len_nxt;  line_len_r <= line_len_nxt;
      kw_mask_r <= kw_mask_nxt;  blank_r <= blank_nxt;  seen_space_r <= seen_space_nxt;
      vphase_r <= vphase_nxt;  acc_r <= acc_nxt;  code_r <= code_nxt;
      clen_r <= clen_nxt;  flags_r <= flags_nxt;
    end
  end

endmodule

### rtl/hrhc_out_stage.sv
// result register of the header classifier
module hrhc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hrhc_pkg::result_t res,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output hrhc_pkg::result_t out_word
);
  import hrhc_pkg::*;

  logic    valid_r, valid_nxt;
  result_t word_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      word_r <= res;
    end
  end

endmodule

### rtl/http_reply_header_classifier.sv
// top level: http reply header classifier, one byte per cycle
// a verdict word reaches out_valid through the input register and then the result register
// throughput: one byte per cycle while out_ready is high; the byte update is a single
// combinational pass between the input register and the parse state
// reset (rst_n low, synchronous) clears the parse state and empties both registers;
// in_start_reply clears the parse state just before its byte is taken
module http_reply_header_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_start_reply,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic [15:0] out_status_code,
  output logic [31:0] out_body_length,
  output logic        out_has_date,
  output logic        out_has_expires,
  output logic        out_has_last_modified,
  output logic        out_has_content_type,
  output logic [12:0] out_header_size
);
  import hrhc_pkg::*;

  in_word_t word;
  logic     word_valid;
  logic     space;
  logic     fire;
  logic     res_valid;
  result_t  res;
  result_t  out_word;

  // a buffered byte moves on once the result register can take a word
  assign fire = word_valid && space;

  hrhc_in_stage u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_value  (in_byte_value),
    .in_start_reply (in_start_reply),
    .take           (fire),
    .word_valid     (word_valid),
    .word           (word)
  );

  hrhc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .word      (word),
    .res_valid (res_valid),
    .res       (res)
  );

  hrhc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign out_verdict           = 3'(out_word.verdict);
  assign out_status_code       = out_word.status_code;
  assign out_body_length       = out_word.body_length;
  assign out_has_date          = out_word.has_date;
  assign out_has_expires       = out_word.has_expires;
  assign out_has_last_modified = out_word.has_last_modified;
  assign out_has_content_type  = out_word.has_content_type;
  assign out_header_size       = out_word.header_size;

endmodule

### tb/tb.sv
// testbench for the http reply header classifier: directed and random replies vs a byte model
module tb;
  import hrhc_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;

  typedef enum logic [1:0] {NUM_SKIP, NUM_POS, NUM_NEG, NUM_STOP} num_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_start_reply = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_verdict;
  logic [15:0] out_status_code;
  logic [31:0] out_body_length;
  logic        out_has_date;
  logic        out_has_expires;
  logic        out_has_last_modified;
  logic        out_has_content_type;
  logic [12:0] out_header_size;

  http_reply_header_classifier dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte_value(in_byte_value),
    .in_start_reply(in_start_reply),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_verdict(out_verdict),
    .out_status_code(out_status_code),
    .out_body_length(out_body_length),
    .out_has_date(out_has_date),
    .out_has_expires(out_has_expires),
    .out_has_last_modified(out_has_last_modified),
    .out_has_content_type(out_has_content_type),
    .out_header_size(out_header_size)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  in_word_t reply_bytes [$];
  result_t  due_verdicts [$];
  in_word_t next_word;
  result_t  predicted;
  bit       reply_open = 1'b0;
  int       queued = 0;
  int       bytes_taken = 0;
  int       verdicts_checked = 0;
  int       replies_sent = 0;
  int       errors = 0;
  int       verdict_tally [5] = '{0, 0, 0, 0, 0};
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_asks = 0;
  int       hold_done = 0;
  int       hold_left = 0;
  int       quiet_cycles = 0;

  // parse state of the byte model
  bit          parse_done;
  int          hdr_cnt;
  int          line_cnt;
  logic [5:0]  kw_live;
  logic [1:0]  blank_st;
  bit          in_value;
  num_state_t  num_st;
  logic [31:0] num_acc;
  logic [15:0] code_q;
  logic [31:0] len_q;
  logic [3:0]  flag_q;

  function automatic string keyword(input field_t f);
    case (f)
      FLD_CODE:    return "http";
      FLD_CTYPE:   return "content-type:";
      FLD_CLEN:    return "content-length:";
      FLD_DATE:    return "date:";
      FLD_EXPIRES: return "expires:";
      default:     return "last-modified:";
    endcase
  endfunction

  function automatic field_t live_field();
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (kw_live[k]) return field_t'(k);
    end
    return FLD_NONE;
  endfunction

  function automatic void fresh_line();
    line_cnt = 0;
    kw_live  = '1;
    in_value = 1'b0;
    num_st   = NUM_SKIP;
    num_acc  = '0;
  endfunction

  function automatic void restart_parse();
    parse_done = 1'b0;
    hdr_cnt    = 0;
    blank_st   = '0;
    code_q     = '0;
    len_q      = '0;
    flag_q     = '0;
    fresh_line();
  endfunction

  function automatic void open_value();
    num_st  = NUM_SKIP;
    num_acc = '0;
    case (live_field())
      FLD_CODE:    code_q = '0;
      FLD_CLEN:    len_q = '0;
      FLD_DATE:    flag_q[FLAG_DATE] = 1'b1;
      FLD_EXPIRES: flag_q[FLAG_EXP] = 1'b0;
      FLD_LM:      flag_q[FLAG_LM] = 1'b1;
      FLD_CTYPE:   flag_q[FLAG_CTYPE] = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic void value_byte(input logic [7:0] b);
    field_t      f;
    bit          digit;
    bit          blank;
    logic [31:0] d;
    f     = live_field();
    digit = (b >= "0") && (b <= "9");
    blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_VT) || (b == CH_FF);
    if (b != CH_CR && f == FLD_EXPIRES) flag_q[FLAG_EXP] = 1'b1;
    if (num_st == NUM_SKIP && !digit) begin
      if (!blank) num_st = (b == CH_PLUS) ? NUM_POS : (b == CH_MINUS) ? NUM_NEG : NUM_STOP;
    end else if (num_st != NUM_STOP) begin
      if (!digit) begin
        num_st = NUM_STOP;
      end else begin
        if (num_st == NUM_SKIP) num_st = NUM_POS;
        d = 32'(b) - 32'h30;
        // decimal accumulate, sticks at all ones
        if (num_acc > (32'hFFFF_FFFF - d) / 32'd10) num_acc = '1;
        else num_acc = num_acc * 32'd10 + d;
        if (f == FLD_CODE)
          code_q = (num_st == NUM_NEG) ? 16'd0 :
                   (num_acc > 32'hFFFF) ? 16'hFFFF : num_acc[15:0];
        else if (f == FLD_CLEN)
          len_q = (num_st == NUM_NEG) ? 32'd0 : num_acc;
      end
    end
  endfunction

  function automatic void line_byte(input logic [7:0] b);
    logic [7:0] c;
    logic [5:0] m;
    string      s;
    if (!in_value) begin
      c = (b >= "A" && b <= "Z") ? b + 8'h20 : b;
      m = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        s = keyword(field_t'(k));
        if (kw_live[k] && (line_cnt >= s.len() || c == s[line_cnt])) m[k] = 1'b1;
      end
      kw_live = m;
      if (b == CH_SPACE) begin
        in_value = 1'b1;
        open_value();
      end
    end else begin
      value_byte(b);
    end
    if (line_cnt < 8191) line_cnt++;
  endfunction

  function automatic verdict_t verdict_for_code();
    bit exp_set;
    exp_set = flag_q[FLAG_EXP];
    case (code_q)
      16'd200, 16'd203, 16'd300, 16'd301, 16'd410:
        return VERDICT_PUBLIC;
      16'd302:
        return exp_set ? VERDICT_PUBLIC : VERDICT_PRIVATE;
      16'd204, 16'd305, 16'd400, 16'd403, 16'd404, 16'd405, 16'd414,
      16'd500, 16'd501, 16'd502, 16'd503, 16'd504:
        return exp_set ? VERDICT_PUBLIC : VERDICT_NEGATIVE;
      default:
        return VERDICT_PRIVATE;
    endcase
  endfunction

  function automatic result_t seal(input verdict_t v);
    result_t r;
    r.verdict           = v;
    r.status_code       = code_q;
    r.body_length       = len_q;
    r.has_date          = flag_q[FLAG_DATE];
    r.has_expires       = flag_q[FLAG_EXP];
    r.has_last_modified = flag_q[FLAG_LM];
    r.has_content_type  = flag_q[FLAG_CTYPE];
    r.header_size       = 13'(hdr_cnt);
    parse_done = 1'b1;
    return r;
  endfunction

  // returns 1 when this byte closes the reply with a verdict
  function automatic bit parse_byte(input logic [7:0] b, input logic start, output result_t r);
    string m;
    m = "HTTP/";
    if (start) restart_parse();
    if (parse_done) return 1'b0;
    hdr_cnt++;
    if (hdr_cnt <= MAGIC_LEN && b != m[hdr_cnt-1]) begin
      r = seal(VERDICT_NOT_HTTP);
      return 1'b1;
    end
    if (b == CH_LF) begin
      if (blank_st != 0) begin
        r = seal(verdict_for_code());
        return 1'b1;
      end
      blank_st = 2'd1;
      fresh_line();
    end else begin
      blank_st = (b == CH_CR && blank_st != 0) ? 2'd2 : 2'd0;
      line_byte(b);
    end
    if (hdr_cnt >= HEADER_LIMIT) begin
      r = seal(VERDICT_OVERFLOW);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------- stimulus builders ----------------
  task automatic put(input logic [7:0] b);
    reply_bytes.push_back('{byte_value: b, start_reply: reply_open});
    reply_open = 1'b0;
    queued++;
  endtask

  task automatic open_reply();
    reply_open = 1'b1;
    replies_sent++;
  endtask

  task automatic put_text(input string s, input bit mix_case);
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (mix_case && (ch | 8'h20) >= "a" && (ch | 8'h20) <= "z" && $urandom_range(1) == 1)
        ch = ch ^ 8'h20;
      put(ch);
    end
  endtask

  task automatic put_eol();
    case ($urandom_range(9))
      0: begin put(CH_CR); put(CH_CR); end
      1, 2, 3, 4: put(CH_CR);
      default: ;
    endcase
    put(CH_LF);
  endtask

  task automatic crlf();
    put(CH_CR);
    put(CH_LF);
  endtask

  task automatic put_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(255));
      if (b == CH_LF) b = 8'hFF;
      put(b);
    end
  endtask

  function automatic int common_code();
    int codes [18];
    codes = '{200, 203, 300, 301, 410, 302, 204, 305, 400,
              403, 404, 405, 414, 500, 501, 502, 503, 504};
    return codes[$urandom_range(17)];
  endfunction

  task automatic put_number();
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(4))
        0: put(CH_SPACE);
        1: put(CH_TAB);
        2: put(CH_VT);
        3: put(CH_FF);
        default: put(CH_CR);
      endcase
    end
    case ($urandom_range(9))
      0: put(CH_PLUS);
      1: put(CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: put_text($sformatf("%0d", common_code()), 0);
      4: put_text($sformatf("%0d", $urandom_range(999)), 0);
      5: put_text($sformatf("%0d", $urandom()), 0);
      6: begin
        if ($urandom_range(1)) put_text("4294967296", 0);
        else put_text("99999999999999999999", 0);
      end
      7: ;
      8: put_text($sformatf("%0d", $urandom_range(70000, 65530)), 0);
      default: put_text("0", 0);
    endcase
    if ($urandom_range(3) == 0) put_noise($urandom_range(4));
  endtask

  task automatic put_header_line();
    string name;
    bit    numeric;
    int    kind;
    numeric = 1'b0;
    kind = $urandom_range(9);
    case (kind)
      0: name = "Content-type:";
      1: begin name = "Content-length:"; numeric = 1'b1; end
      2: name = "Date:";
      4: name = "Last-Modified:";
      5: begin name = "HTTP/1.1"; numeric = 1'b1; end
      6: begin
        case ($urandom_range(4))
          0: name = "Content-typ:";
          1: name = "Date";
          2: name = "Expires:soon";
          3: name = "Last-Modified";
          default: name = "Content-lengthy:";
        endcase
      end
      7: begin
        put_noise($urandom_range(12));
        put_eol();
        return;
      end
      8: name = "Server:";
      default: name = "Expires:";
    endcase
    put_text(name, 1'b1);
    if ($urandom_range(9) != 0) begin
      put(CH_SPACE);
      if (numeric) begin
        put_number();
      end else if ((kind == 3 || kind == 9) && $urandom_range(2) == 0) begin
        // empty expires value, maybe a lone carriage return
        if ($urandom_range(1)) put(CH_CR);
      end else begin
        put_noise($urandom_range(10, 1));
      end
    end
    put_eol();
  endtask

  task automatic put_reply();
    string m;
    int    bad;
    m = "HTTP/";
    open_reply();
    if ($urandom_range(19) == 0) begin
      bad = $urandom_range(4);
      for (int i = 0; i < MAGIC_LEN; i++)
        put((i == bad) ? (8'(m[i]) ^ 8'($urandom_range(255, 1))) : 8'(m[i]));
      put_noise($urandom_range(6));
      return;
    end
    put_text("HTTP/", 1'b0);
    if ($urandom_range(1)) put_text("1.1", 1'b0);
    else put_text("1.0", 1'b0);
    repeat ($urandom_range(2, 1)) put(CH_SPACE);
    put_number();
    if ($urandom_range(1)) put_text(" OK", 1'b1);
    put_eol();
    repeat ($urandom_range(4)) put_header_line();
    if ($urandom_range(15) == 0) return;  // cut short, no verdict
    put_eol();
    if ($urandom_range(3) == 0) put_noise($urandom_range(5, 1));
  endtask

  task automatic put_directed();
    open_reply();
    put_text("HTTP/1.0 200 OK", 0); crlf();
    put_text("Content-Type: text/html", 0); crlf();
    put_text("Content-Length: 1234", 0); crlf();
    put_text("Date: today", 0); crlf();
    put_text("Last-Modified: never", 0); crlf();
    crlf();
    open_reply();
    put_text("HTTP/1.1 302 Found\nExpires: ", 0); crlf(); put(CH_LF);
    open_reply();
    put_text("HTTP/1.1 404 x\nEXPIRES: later\n\n", 0);
    open_reply();
    put_text("HTTP/1.0 503\n\n", 0);
    open_reply();
    put_text("HTTP/1.0 -7\ncontent-length: -12\n\n", 0);
    open_reply();
    put_text("HTTP/1.0 99999\ncontent-length: 99999999999\n", 0);
    put(CH_CR); put(CH_CR); put(CH_LF);
    open_reply();
    put_text("HTTX/zz", 0);
    open_reply();
    put_text("http/", 0);
    // restart in the middle of a reply
    open_reply();
    put_text("HTTP/1.0 2", 0);
    open_reply();
    put_text("HTTP/1.0 \t+200x\n", 0);
    put(8'h00); put(8'hFF); put(CH_LF); put(CH_LF);
    open_reply();
    put(8'h00);
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (reply_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = reply_bytes.pop_front();
        in_valid       <= 1'b1;
        in_byte_value  <= next_word.byte_value;
        in_start_reply <= next_word.start_reply;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_done != hold_asks) begin
      hold_done <= hold_asks;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_verdict();
    result_t got;
    result_t want;
    string   bad;
    got.verdict           = verdict_t'(out_verdict);
    got.status_code       = out_status_code;
    got.body_length       = out_body_length;
    got.has_date          = out_has_date;
    got.has_expires       = out_has_expires;
    got.has_last_modified = out_has_last_modified;
    got.has_content_type  = out_has_content_type;
    got.header_size       = out_header_size;
    bad = "";
    if (due_verdicts.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected verdict word: verdict=%0d code=%0d len=%0d size=%0d",
                 got.verdict, got.status_code, got.body_length, got.header_size);
      return;
    end
    want = due_verdicts.pop_front();
    verdicts_checked++;
    verdict_tally[want.verdict]++;
    if (got.verdict !== want.verdict) bad = {bad, " verdict"};
    if (got.status_code !== want.status_code) bad = {bad, " status_code"};
    if (got.body_length !== want.body_length) bad = {bad, " body_length"};
    if (got.has_date !== want.has_date) bad = {bad, " has_date"};
    if (got.has_expires !== want.has_expires) bad = {bad, " has_expires"};
    if (got.has_last_modified !== want.has_last_modified) bad = {bad, " has_last_modified"};
    if (got.has_content_type !== want.has_content_type) bad = {bad, " has_content_type"};
    if (got.header_size !== want.header_size) bad = {bad, " header_size"};
    if (bad != "") begin
      errors++;
      if (errors <= 10) begin
        $display("verdict word %0d mismatch in:%s", verdicts_checked, bad);
        $display("  expected verdict=%0d code=%0d len=%0d date/exp/lm/ctype=%b%b%b%b size=%0d",
                 want.verdict, want.status_code, want.body_length, want.has_date,
                 want.has_expires, want.has_last_modified, want.has_content_type,
                 want.header_size);
        $display("  actual   verdict=%0d code=%0d len=%0d date/exp/lm/ctype=%b%b%b%b size=%0d",
                 got.verdict, got.status_code, got.body_length, got.has_date,
                 got.has_expires, got.has_last_modified, got.has_content_type,
                 got.header_size);
      end
    end
  endtask

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      restart_parse();
    end else begin
      if (out_valid && out_ready) check_verdict();
      if (in_valid && in_ready) begin
        bytes_taken++;
        if (parse_byte(in_byte_value, in_start_reply, predicted)) due_verdicts.push_back(predicted);
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: no word moving while work is outstanding
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        !(in_valid || due_verdicts.size() != 0)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no progress for %0d cycles, %0d verdicts outstanding",
               quiet_cycles, due_verdicts.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    int mark;
    int first_reply;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      if (ph == 0) begin
        put_directed();
      end
      mark = queued;
      first_reply = replies_sent;
      while (queued - mark < 360 || replies_sent - first_reply < 12) put_reply();
      // receiver goes quiet while the sender keeps pushing
      if (ph == 0) hold_asks++;
      while (reply_bytes.size() != 0 || in_valid || due_verdicts.size() != 0) @(negedge clk);
    end
    repeat (10) @(posedge clk);
    $display("%0d bytes in %0d replies, %0d verdicts checked, %0d errors", bytes_taken,
             replies_sent, verdicts_checked, errors);
    $display("verdicts: public %0d, private %0d, negative %0d, not http %0d, overflow %0d",
             verdict_tally[VERDICT_PUBLIC], verdict_tally[VERDICT_PRIVATE],
             verdict_tally[VERDICT_NEGATIVE], verdict_tally[VERDICT_NOT_HTTP],
             verdict_tally[VERDICT_OVERFLOW]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### http_reply_header_classifier.f
rtl/hrhc_pkg.sv
rtl/hrhc_in_stage.sv
rtl/hrhc_parser.sv
rtl/hrhc_out_stage.sv
rtl/http_reply_header_classifier.sv
tb/tb.sv
